// ===== rtl/swk_pkg.sv =====
// Shared types and constants of the sliding-window kurtosis/skewness block.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package swk_pkg;

  // Port and accumulator widths.
  localparam int SAMPLE_W = 12;
  localparam int WLEN_W   = 11;
  localparam int STAT_W   = 32;
  localparam int S2_W     = 33;
  localparam int S3_W     = 45;
  localparam int S4_W     = 55;

  // Long arithmetic: product/remainder width, multiplier operand and digit.
  localparam int WIDE_W  = 140;
  localparam int B_W     = 45;
  localparam int DIGIT_W = 8;

  // Quotient of the long divide and the integer square root.
  localparam int QUO_W  = 43;
  localparam int ROOT_W = 22;
  localparam int ITER_W = 6;

  // Fixed-point scaling of the numerators (Q16.16 result).
  localparam int KURT_SHIFT = 16;
  localparam int SKEW_SHIFT = 32;

  // Configuration register indexes.
  localparam logic REG_WINDOW_LENGTH  = 1'b0;
  localparam logic REG_STATISTIC_MODE = 1'b1;

  localparam logic [WLEN_W-1:0] WLEN_RESET = 11'd100;

  // Statistic modes.
  localparam logic MODE_KURTOSIS = 1'b0;
  localparam logic MODE_SKEWNESS = 1'b1;

  // Products built by the serial multiplier.
  typedef enum logic [2:0] {
    MUL_DEN_SQ,
    MUL_DEN_CU,
    MUL_S3_SQ,
    MUL_NUM_KURT,
    MUL_NUM_SKEW
  } mul_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     rd;
    logic     pow1;
    logic     pow2;
    logic     upd;
    logic     mul_load;
    logic     mul_step;
    logic     mul_save;
    mul_sel_t mul_sel;
    logic     div_init;
    logic     div_step;
    logic     sqrt_init;
    logic     sqrt_step;
    logic     finish;
  } swk_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode;
    logic stat_ok;
    logic mul_done;
    logic iter_zero;
    logic out_busy;
  } swk_status_t;

endpackage

`default_nettype wire

// ===== rtl/sliding_window_kurtosis_skewness.sv =====
// Sliding-window kurtosis / skewness of a zero-mean sample stream: one
// signed sample in, one Q16.16 statistic out per sample. The time an
// item takes is set by the 43-step restoring divider, the 22-step square
// root of skewness mode and the 8-bit-a-cycle serial multiplier that
// builds S2^2, S2^3, S3^2 and the scaled numerators; in warm-up or at
// zero energy these are skipped. A new sample is taken once the previous
// one is finished, even while its result still waits at the output.
// Writing window_length restarts the trace.
// Uses swk_pkg, swk_ctrl and swk_datapath.
`default_nettype none

module sliding_window_kurtosis_skewness
  import swk_pkg::*;
#(
  parameter int WINDOW_MAX  = 1024,
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic                       trace_start,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [STAT_W-1:0]        statistic,
  output logic                            statistic_valid,
  input  wire logic                       cfg_write_en,
  input  wire logic                       cfg_index,
  input  wire logic [WLEN_W-1:0]          cfg_data
);

  swk_cmd_t    cmd;
  swk_status_t status;

  swk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  swk_datapath #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .sample          (sample),
    .trace_start     (trace_start),
    .cfg_write_en    (cfg_write_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .statistic       (statistic),
    .statistic_valid (statistic_valid)
  );

endmodule

`default_nettype wire

// ===== rtl/swk_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module swk_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1025
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/swk_ctrl.sv =====
// Controller of the sliding-window kurtosis/skewness block: sequences the
// sum update, serial multiplies, long divide and square root. Uses swk_pkg.
`default_nettype none

module swk_ctrl
  import swk_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire swk_status_t status,
  output swk_cmd_t         cmd
);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_RD    = 12'b0000_0000_0010,
    ST_POW1  = 12'b0000_0000_0100,
    ST_POW2  = 12'b0000_0000_1000,
    ST_UPD   = 12'b0000_0001_0000,
    ST_MLOAD = 12'b0000_0010_0000,
    ST_MRUN  = 12'b0000_0100_0000,
    ST_DINIT = 12'b0000_1000_0000,
    ST_DRUN  = 12'b0001_0000_0000,
    ST_SINIT = 12'b0010_0000_0000,
    ST_SRUN  = 12'b0100_0000_0000,
    ST_FIN   = 12'b1000_0000_0000
  } state_t;

  state_t   state, state_next;
  mul_sel_t mul_sel, mul_sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      mul_sel <= MUL_DEN_SQ;
    end else begin
      state   <= state_next;
      mul_sel <= mul_sel_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  // Next state and commands
  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = mul_sel;
    state_next   = state;
    mul_sel_next = mul_sel;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_POW1;
      end
      ST_POW1: begin
        cmd.pow1   = 1'b1;
        state_next = ST_POW2;
      end
      ST_POW2: begin
        cmd.pow2   = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd      = 1'b1;
        mul_sel_next = MUL_DEN_SQ;
        state_next   = ST_MLOAD;
      end
      ST_MLOAD: begin
        // skip the arithmetic in warm-up or at zero energy
        if (!status.stat_ok) begin
          state_next = ST_FIN;
        end else begin
          cmd.mul_load = 1'b1;
          state_next   = ST_MRUN;
        end
      end
      ST_MRUN: begin
        if (status.mul_done) begin
          cmd.mul_save = 1'b1;
          state_next   = ST_MLOAD;
          unique case (mul_sel)
            MUL_DEN_SQ: begin
              mul_sel_next = (status.mode == MODE_KURTOSIS) ? MUL_NUM_KURT : MUL_DEN_CU;
            end
            MUL_DEN_CU: mul_sel_next = MUL_S3_SQ;
            MUL_S3_SQ:  mul_sel_next = MUL_NUM_SKEW;
            MUL_NUM_KURT, MUL_NUM_SKEW: state_next = ST_DINIT;
            default: state_next = ST_DINIT;
          endcase
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        state_next   = ST_DRUN;
      end
      ST_DRUN: begin
        cmd.div_step = 1'b1;
        if (status.iter_zero) begin
          state_next = (status.mode == MODE_KURTOSIS) ? ST_FIN : ST_SINIT;
        end
      end
      ST_SINIT: begin
        cmd.sqrt_init = 1'b1;
        state_next    = ST_SRUN;
      end
      ST_SRUN: begin
        cmd.sqrt_step = 1'b1;
        if (status.iter_zero) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the output register can take the beat
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/swk_datapath.sv =====
// Datapath of the sliding-window kurtosis/skewness block: sample history,
// running power sums, serial multiplier, divider, square root, output beat.
// Uses swk_pkg and swk_ram.
`default_nettype none

module swk_datapath
  import swk_pkg::*;
#(
  parameter int WINDOW_MAX  = 1024,
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire swk_cmd_t                   cmd,
  output swk_status_t                     status,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic                       trace_start,
  input  wire logic                       cfg_write_en,
  input  wire logic                       cfg_index,
  input  wire logic [WLEN_W-1:0]          cfg_data,
  input  wire logic                       out_stall,
  output logic                            out_valid,
  output logic signed [STAT_W-1:0]        statistic,
  output logic                            statistic_valid
);

  localparam int DEPTH = WINDOW_MAX + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(WINDOW_MAX + 2);
  localparam int MAG_W = STAT_W - 1;

  // Configuration
  logic [WLEN_W-1:0] window_length;
  logic              statistic_mode;

  // Trace state
  logic [AW-1:0]            ptr;
  logic [CNT_W-1:0]         seen;
  logic [S2_W-1:0]          s2;
  logic signed [S3_W-1:0]   s3;
  logic [S4_W-1:0]          s4;
  logic signed [SAMPLE_W-1:0] x;

  // Powers of the new and the oldest sample
  logic signed [2*SAMPLE_W-1:0] x2, o2;
  logic signed [3*SAMPLE_W-1:0] x3, o3;
  logic signed [4*SAMPLE_W-1:0] x4, o4;

  logic stat_ok, neg;

  // Long arithmetic
  logic [WIDE_W-1:0] a_sh, acc, den, num, rem, dsh;
  logic [B_W-1:0]    b_sh;
  logic [QUO_W-1:0]  quo;
  logic [ROOT_W-1:0] root;
  logic [ITER_W-1:0] iter;

  logic [CNT_W-1:0]            n_eff, np1;
  logic [AW:0]                 ptr_ext, np1_ext;
  logic [AW-1:0]               old_addr;
  logic                        sub_old;
  logic [SAMPLE_BITS-1:0]      ram_rdata;
  logic signed [SAMPLE_BITS-1:0] o_low, x_low;
  logic signed [SAMPLE_W-1:0]  o;
  logic [S2_W-1:0]             s2_next;
  logic signed [S3_W-1:0]      s3_next;
  logic [S4_W-1:0]             s4_next;
  logic                        clear;
  logic [B_W-1:0]              s3_abs;
  logic [WIDE_W-1:0]           op_a;
  logic [B_W-1:0]              op_b;
  logic                        div_ge;
  logic [ROOT_W-1:0]           root_try;
  logic [2*ROOT_W-1:0]         root_sq;
  logic [MAG_W-1:0]            mag;
  logic [STAT_W-1:0]           stat_val;

  // Effective window length: zero acts as one, clamp to the maximum
  always_comb begin
    if (window_length == '0) begin
      n_eff = CNT_W'(1);
    end else if (window_length > WLEN_W'(WINDOW_MAX)) begin
      n_eff = CNT_W'(WINDOW_MAX);
    end else begin
      n_eff = CNT_W'(window_length);
    end
  end
  assign np1 = n_eff + CNT_W'(1);

  // Ring address of the sample leaving the window
  assign ptr_ext = {1'b0, ptr};
  assign np1_ext = (AW+1)'(np1);
  assign old_addr = (ptr_ext >= np1_ext) ? AW'(ptr_ext - np1_ext)
                                         : AW'(ptr_ext + (AW+1)'(DEPTH) - np1_ext);
  assign sub_old = (seen >= np1);

  assign clear = (cmd.load && trace_start) ||
                 (cfg_write_en && cfg_index == REG_WINDOW_LENGTH);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length  <= WLEN_RESET;
      statistic_mode <= MODE_KURTOSIS;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH:  window_length  <= cfg_data;
        REG_STATISTIC_MODE: statistic_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sample history
  swk_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (cmd.upd),
    .waddr (ptr),
    .wdata (x[SAMPLE_BITS-1:0]),
    .re    (cmd.rd),
    .raddr (old_addr),
    .rdata (ram_rdata)
  );

  assign x_low = sample[SAMPLE_BITS-1:0];
  assign o_low = ram_rdata;
  assign o     = sub_old ? SAMPLE_W'(o_low) : '0;

  // Latch the sample, sign-extended from its low bits
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x <= SAMPLE_W'(x_low);
    end
  end

  // Powers, one multiplier level per cycle
  always_ff @(posedge clk) begin
    if (cmd.pow1) begin
      x2 <= x * x;
      o2 <= o * o;
    end
    if (cmd.pow2) begin
      x3 <= x2 * x;
      o3 <= o2 * o;
      x4 <= x2 * x2;
      o4 <= o2 * o2;
    end
  end

  assign s2_next = s2 + S2_W'(x2) - S2_W'(o2);
  assign s3_next = s3 + S3_W'(x3) - S3_W'(o3);
  assign s4_next = s4 + S4_W'(x4) - S4_W'(o4);

  // Running sums, ring pointer and fill count
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      ptr  <= '0;
      seen <= '0;
      s2   <= '0;
      s3   <= '0;
      s4   <= '0;
    end else if (cmd.upd) begin
      s2  <= s2_next;
      s3  <= s3_next;
      s4  <= s4_next;
      ptr <= (ptr == AW'(DEPTH - 1)) ? '0 : ptr + AW'(1);
      if (seen < np1) begin
        seen <= seen + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      stat_ok <= (seen >= n_eff) && (s2_next != '0);
      neg     <= s3_next[S3_W-1];
    end
  end

  // Serial multiplier operands
  assign s3_abs = s3[S3_W-1] ? B_W'(-s3) : B_W'(s3);

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_DEN_SQ: begin
        op_a = WIDE_W'(s2);
        op_b = B_W'(s2);
      end
      MUL_DEN_CU: begin
        op_a = den;
        op_b = B_W'(s2);
      end
      MUL_S3_SQ: begin
        op_a = WIDE_W'(s3_abs);
        op_b = s3_abs;
      end
      MUL_NUM_KURT: begin
        op_a = WIDE_W'(s4);
        op_b = B_W'(n_eff);
      end
      MUL_NUM_SKEW: begin
        op_a = num;
        op_b = B_W'(n_eff);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Multiply one digit of B a cycle; save into the denominator or numerator
  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      a_sh <= op_a;
      b_sh <= op_b;
      acc  <= '0;
    end else if (cmd.mul_step) begin
      acc  <= acc + a_sh * b_sh[DIGIT_W-1:0];
      a_sh <= a_sh << DIGIT_W;
      b_sh <= b_sh >> DIGIT_W;
    end
    if (cmd.mul_save) begin
      unique case (cmd.mul_sel)
        MUL_DEN_SQ, MUL_DEN_CU: den <= acc;
        MUL_S3_SQ:              num <= acc;
        MUL_NUM_KURT:           num <= acc << KURT_SHIFT;
        MUL_NUM_SKEW:           num <= acc << SKEW_SHIFT;
        default: ;
      endcase
    end
  end

  // Restoring divide, one quotient bit a cycle; then square root bit by bit
  assign div_ge   = (rem >= dsh);
  assign root_try = root | (ROOT_W'(1) << iter);
  assign root_sq  = (2*ROOT_W)'(root_try) * (2*ROOT_W)'(root_try);

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem  <= num;
      dsh  <= den << (QUO_W - 1);
      quo  <= '0;
      iter <= ITER_W'(QUO_W - 1);
    end else if (cmd.div_step) begin
      if (div_ge) begin
        rem <= rem - dsh;
      end
      quo  <= {quo[QUO_W-2:0], div_ge};
      dsh  <= dsh >> 1;
      iter <= iter - ITER_W'(1);
    end else if (cmd.sqrt_init) begin
      root <= '0;
      iter <= ITER_W'(ROOT_W - 1);
    end else if (cmd.sqrt_step) begin
      if (root_sq <= (2*ROOT_W)'(quo)) begin
        root <= root_try;
      end
      iter <= iter - ITER_W'(1);
    end
  end

  // Result magnitude and sign
  always_comb begin
    if (statistic_mode == MODE_KURTOSIS) begin
      mag = (quo[QUO_W-1:MAG_W] != '0) ? '1 : quo[MAG_W-1:0];
    end else begin
      mag = MAG_W'(root);
    end
    if (statistic_mode == MODE_SKEWNESS && neg) begin
      stat_val = -{1'b0, mag};
    end else begin
      stat_val = {1'b0, mag};
    end
  end

  // Output register: load on finish, drop when the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      statistic       <= stat_ok ? signed'(stat_val) : '0;
      statistic_valid <= stat_ok;
    end
  end

  assign status.mode      = statistic_mode;
  assign status.stat_ok   = stat_ok;
  assign status.mul_done  = (b_sh == '0);
  assign status.iter_zero = (iter == '0);
  assign status.out_busy  = out_valid && out_stall;

endmodule

`default_nettype wire
